FILE: hdl/lccdf_pkg.sv
`timescale 1ns / 1ps

package lccdf_pkg;

	// register and counter widths
	localparam int CFG_W   = 24;
	localparam int EXP_W   = 24;
	localparam int BYTE_W  = 8;
	localparam int CNT_W   = 8;
	localparam int CIDX_W  = 2;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_EXPOSURE   = 2'd0;
	localparam logic [CIDX_W-1:0] REG_CLAMP_LOW  = 2'd1;
	localparam logic [CIDX_W-1:0] REG_CLAMP_HIGH = 2'd2;

	// register reset values
	localparam logic [EXP_W-1:0]  EXPOSURE_RST   = 24'd10000;
	localparam logic [BYTE_W-1:0] CLAMP_LOW_RST  = 8'h03;
	localparam logic [BYTE_W-1:0] CLAMP_HIGH_RST = 8'hFE;

	// frame bytes
	localparam logic [BYTE_W-1:0] HEAD_BYTE0 = 8'h01;
	localparam logic [BYTE_W-1:0] HEAD_BYTE1 = 8'h00;
	localparam logic [BYTE_W-1:0] TAIL_BYTE0 = 8'h00;
	localparam logic [BYTE_W-1:0] TAIL_BYTE1 = 8'hFF;

	typedef enum logic [3:0] {
		PH_F_SI_UP    = 4'd0,
		PH_F_SI_CLK   = 4'd1,
		PH_F_SI_DROP  = 4'd2,
		PH_F_CLK_DROP = 4'd3,
		PH_FLUSH      = 4'd4,
		PH_EXPOSE     = 4'd5,
		PH_R_SI_UP    = 4'd6,
		PH_R_SI_CLK   = 4'd7,
		PH_R_SI_DROP  = 4'd8,
		PH_R_CLK_DROP = 4'd9,
		PH_READ       = 4'd10,
		PH_EXTRA_HIGH = 4'd11,
		PH_EXTRA_LOW  = 4'd12
	} phase_t;

	typedef struct packed {
		logic [EXP_W-1:0]  exposure_ticks;
		logic [BYTE_W-1:0] clamp_low;
		logic [BYTE_W-1:0] clamp_high;
	} cfg_t;

	typedef struct packed {
		logic              ccd_clk;
		logic              ccd_si;
		logic              byte_valid;
		logic [BYTE_W-1:0] byte_out;
		logic              frame_last;
	} result_t;

endpackage

FILE: hdl/lccdf_scale.sv
`timescale 1ns / 1ps

module lccdf_scale #(
	parameter int ADC_WIDTH = 12
) (
	input  logic [ADC_WIDTH-1:0]        adc,
	input  lccdf_pkg::cfg_t             cfg,
	output logic [lccdf_pkg::BYTE_W-1:0] pixel
);
	import lccdf_pkg::*;

	localparam int PROD_W = ADC_WIDTH + BYTE_W;

	logic [PROD_W-1:0] prod;
	logic [BYTE_W-1:0] scaled;

	// adc * 255 as a shift and subtract, then drop the fraction
	assign prod   = {adc, {BYTE_W{1'b0}}} - PROD_W'(adc);
	assign scaled = prod[PROD_W-1:ADC_WIDTH];

	// when the limits cross, values above the high limit get it and all others get the low one
	always_comb begin
		if (scaled > cfg.clamp_high) begin
			pixel = cfg.clamp_high;
		end else if (scaled < cfg.clamp_low) begin
			pixel = cfg.clamp_low;
		end else begin
			pixel = scaled;
		end
	end

endmodule

FILE: hdl/lccdf_seq.sv
`timescale 1ns / 1ps

module lccdf_seq #(
	parameter int PIXELS    = 128,
	parameter int ADC_WIDTH = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [ADC_WIDTH-1:0] adc,
	input  lccdf_pkg::cfg_t      cfg,
	output lccdf_pkg::result_t   res
);
	import lccdf_pkg::*;

	localparam logic [CNT_W-1:0] PIX_LAST = CNT_W'(PIXELS);

	phase_t            phase_q, phase_d;
	logic [CNT_W-1:0]  pix_cnt_q, pix_cnt_d;
	logic [EXP_W-1:0]  exp_cnt_q, exp_cnt_d;
	logic              half_q, half_d;

	logic [CNT_W-1:0]  pix_inc;
	logic [EXP_W-1:0]  exp_inc;
	logic              clocks_done;
	logic [BYTE_W-1:0] pixel;

	lccdf_scale #(
		.ADC_WIDTH(ADC_WIDTH)
	) u_scale (
		.adc  (adc),
		.cfg  (cfg),
		.pixel(pixel)
	);

	assign pix_inc     = pix_cnt_q + 1'b1;
	assign exp_inc     = exp_cnt_q + 1'b1;
	assign clocks_done = half_q && (pix_inc >= PIX_LAST);

	// state registers, moved once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_F_SI_UP;
			pix_cnt_q <= '0;
			exp_cnt_q <= '0;
			half_q    <= 1'b0;
		end else if (advance) begin
			phase_q   <= phase_d;
			pix_cnt_q <= pix_cnt_d;
			exp_cnt_q <= exp_cnt_d;
			half_q    <= half_d;
		end
	end

	// next state and pin levels for this tick
	always_comb begin
		phase_d   = phase_q;
		pix_cnt_d = pix_cnt_q;
		exp_cnt_d = exp_cnt_q;
		half_d    = half_q;
		res       = '0;
		case (phase_q)
			PH_F_SI_UP: begin
				res.ccd_si = 1'b1;
				phase_d    = PH_F_SI_CLK;
			end
			PH_R_SI_UP: begin
				res.ccd_si = 1'b1;
				phase_d    = PH_R_SI_CLK;
			end
			PH_F_SI_CLK: begin
				res.ccd_si  = 1'b1;
				res.ccd_clk = 1'b1;
				phase_d     = PH_F_SI_DROP;
			end
			PH_R_SI_CLK: begin
				res.ccd_si     = 1'b1;
				res.ccd_clk    = 1'b1;
				res.byte_valid = 1'b1;
				res.byte_out   = HEAD_BYTE0;
				phase_d        = PH_R_SI_DROP;
			end
			PH_F_SI_DROP: begin
				res.ccd_clk = 1'b1;
				phase_d     = PH_F_CLK_DROP;
			end
			PH_R_SI_DROP: begin
				res.ccd_clk    = 1'b1;
				res.byte_valid = 1'b1;
				res.byte_out   = HEAD_BYTE1;
				phase_d        = PH_R_CLK_DROP;
			end
			PH_F_CLK_DROP: begin
				pix_cnt_d = '0;
				half_d    = 1'b0;
				phase_d   = PH_FLUSH;
			end
			PH_R_CLK_DROP: begin
				pix_cnt_d = '0;
				half_d    = 1'b0;
				phase_d   = PH_READ;
			end
			PH_FLUSH: begin
				res.ccd_clk = !half_q;
				half_d      = !half_q;
				if (half_q) begin
					pix_cnt_d = pix_inc;
				end
				if (clocks_done) begin
					pix_cnt_d = '0;
					exp_cnt_d = '0;
					phase_d   = (cfg.exposure_ticks == '0) ? PH_R_SI_UP : PH_EXPOSE;
				end
			end
			PH_EXPOSE: begin
				exp_cnt_d = exp_inc;
				if (exp_inc >= cfg.exposure_ticks) begin
					exp_cnt_d = '0;
					phase_d   = PH_R_SI_UP;
				end
			end
			PH_READ: begin
				// sample on the high half of each read clock
				res.ccd_clk    = !half_q;
				res.byte_valid = !half_q;
				res.byte_out   = half_q ? '0 : pixel;
				half_d         = !half_q;
				if (half_q) begin
					pix_cnt_d = pix_inc;
				end
				if (clocks_done) begin
					pix_cnt_d = '0;
					phase_d   = PH_EXTRA_HIGH;
				end
			end
			PH_EXTRA_HIGH: begin
				res.ccd_clk    = 1'b1;
				res.byte_valid = 1'b1;
				res.byte_out   = TAIL_BYTE0;
				phase_d        = PH_EXTRA_LOW;
			end
			PH_EXTRA_LOW: begin
				res.byte_valid = 1'b1;
				res.byte_out   = TAIL_BYTE1;
				res.frame_last = 1'b1;
				phase_d        = PH_F_SI_UP;
			end
			default: begin
				phase_d   = PH_F_SI_UP;
				pix_cnt_d = '0;
				exp_cnt_d = '0;
				half_d    = 1'b0;
			end
		endcase
	end

endmodule

FILE: hdl/linear_ccd_readout_framer_top.sv
`timescale 1ns / 1ps

// Linear CCD readout framer. Every accepted input item is one sensor tick
// carrying the current converter sample; it yields exactly one result item
// with the CLK and SI pin levels and, on some ticks, one frame byte. One
// item is taken per clock: the next-state logic of the phase sequencer and
// the pixel scale and clamp are combinational, and the result sits in one
// output register that is refilled in the same cycle it is taken, so each
// result shows in the cycle after its item is taken, and input stalls only
// while that register is full and out_ready is low. Configuration writes
// take effect at once and are meant to be made between items.
module linear_ccd_readout_framer_top #(
	parameter int PIXELS    = 128,
	parameter int ADC_WIDTH = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [ADC_WIDTH-1:0]             adc_sample,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             ccd_clk,
	output logic                             ccd_si,
	output logic                             byte_valid,
	output logic [lccdf_pkg::BYTE_W-1:0]     byte_out,
	output logic                             frame_last,
	input  logic                             cfg_we,
	input  logic [lccdf_pkg::CIDX_W-1:0]     cfg_index,
	input  logic [lccdf_pkg::CFG_W-1:0]      cfg_data
);
	import lccdf_pkg::*;

	cfg_t    cfg_q;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.exposure_ticks <= EXPOSURE_RST;
			cfg_q.clamp_low      <= CLAMP_LOW_RST;
			cfg_q.clamp_high     <= CLAMP_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EXPOSURE:   cfg_q.exposure_ticks <= cfg_data[EXP_W-1:0];
				REG_CLAMP_LOW:  cfg_q.clamp_low      <= cfg_data[BYTE_W-1:0];
				REG_CLAMP_HIGH: cfg_q.clamp_high     <= cfg_data[BYTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	lccdf_seq #(
		.PIXELS   (PIXELS),
		.ADC_WIDTH(ADC_WIDTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(accept),
		.adc    (adc_sample),
		.cfg    (cfg_q),
		.res    (res)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign ccd_clk    = res_q.ccd_clk;
	assign ccd_si     = res_q.ccd_si;
	assign byte_valid = res_q.byte_valid;
	assign byte_out   = res_q.byte_out;
	assign frame_last = res_q.frame_last;

endmodule

FILE: hdl/lccdf_chk.sv
`timescale 1ns / 1ps

module lccdf_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         ccd_clk,
	input logic                         ccd_si,
	input logic                         byte_valid,
	input logic [lccdf_pkg::BYTE_W-1:0] byte_out,
	input logic                         frame_last
);
	import lccdf_pkg::*;

	// last flag only on the closing trailer byte, with both pins low
	a_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |->
			byte_valid && byte_out == TAIL_BYTE1 && !ccd_clk && !ccd_si)
		else $error("frame_last without trailer byte");

	// no byte means a zero byte and no last flag
	a_idle_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> byte_out == '0 && !frame_last)
		else $error("byte_out not zero without byte_valid");

	// with SI high the only byte is the first header byte, on a clock high
	a_si_header: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ccd_si && byte_valid |-> byte_out == HEAD_BYTE0 && ccd_clk)
		else $error("unexpected byte while SI high");

	// a stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(byte_out) && $stable(ccd_clk) && $stable(ccd_si))
		else $error("result item changed while stalled");

endmodule

bind linear_ccd_readout_framer_top lccdf_chk u_lccdf_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.ccd_clk   (ccd_clk),
	.ccd_si    (ccd_si),
	.byte_valid(byte_valid),
	.byte_out  (byte_out),
	.frame_last(frame_last)
);
